// ===== rtl/core/fgim_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgim_pkg
// Shared codes and constants for the FFT grid index mapper.
// ----------------------------------------------------------------------------
package fgim_pkg;

	typedef enum logic [1:0] {
		ACT_SPLIT = 2'd0,
		ACT_JOIN  = 2'd1,
		ACT_NEG   = 2'd2,
		ACT_NONE  = 2'd3
	} act_t;

	localparam logic [1:0] CFG_NUM_DIMS = 2'd0;
	localparam logic [1:0] CFG_SIZE0    = 2'd1;
	localparam logic [1:0] CFG_SIZE1    = 2'd2;
	localparam logic [1:0] CFG_SIZE2    = 2'd3;

	localparam int DVD_W      = 32;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = DVD_W / DIV_STEPS;
	localparam int CFG_W      = 11;
	localparam int COORD_W    = 11;
	localparam int INDEX_W    = 30;

endpackage

// ===== rtl/core/fgim_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgim_front
// Holds the configuration, clamps sizes and dimensions, and turns each
// request into per-lane dividends for the division pipeline.
// ----------------------------------------------------------------------------
module fgim_front #(
	parameter int MAX_SIDE = 1024,
	parameter int MAX_DIMS = 3,
	parameter int SW       = $clog2(MAX_SIDE + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [1:0]                    wr_index,
	input  logic [fgim_pkg::CFG_W-1:0]    wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic [fgim_pkg::INDEX_W-1:0]  index_in,
	input  logic                          zero_centered,
	input  logic signed [31:0]            coord_in_0,
	input  logic signed [31:0]            coord_in_1,
	input  logic signed [31:0]            coord_in_2,
	output logic                          req_valid,
	input  logic                          req_ready,
	output logic [3*SW+101:0]             req
);

	typedef struct packed {
		fgim_pkg::act_t                          act;
		logic                                    zc;
		logic [2:0][SW-1:0]                      sz;
		logic [2:0][fgim_pkg::DVD_W-1:0]         dvd;
		logic [2:0]                              neg;
	} req_t;

	logic [1:0]                        nd_q;
	logic [2:0][fgim_pkg::CFG_W-1:0]   sz_q;
	logic                              vld_s1;
	req_t                              req_s1;
	req_t                              nx;
	logic [1:0]                        d;
	logic [2:0][31:0]                  cin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q <= 2'd3;
			sz_q <= {3{11'd64}};
		end else if (wr_en) begin
			unique case (wr_index)
				fgim_pkg::CFG_NUM_DIMS: nd_q    <= wr_data[1:0];
				fgim_pkg::CFG_SIZE0:    sz_q[0] <= wr_data;
				fgim_pkg::CFG_SIZE1:    sz_q[1] <= wr_data;
				fgim_pkg::CFG_SIZE2:    sz_q[2] <= wr_data;
				default: ;
			endcase
		end
	end

	assign cin[0] = coord_in_0;
	assign cin[1] = coord_in_1;
	assign cin[2] = coord_in_2;

	always_comb begin
		if (nd_q == 2'd0)
			d = 2'd1;
		else if (32'(nd_q) > MAX_DIMS)
			d = 2'(MAX_DIMS);
		else
			d = nd_q;
		nx     = '0;
		nx.act = fgim_pkg::act_t'(action);
		nx.zc  = zero_centered;
		for (int i = 0; i < 3; i++) begin
			if (sz_q[i] == '0)
				nx.sz[i] = SW'(1);
			else if (32'(sz_q[i]) > MAX_SIDE)
				nx.sz[i] = SW'(MAX_SIDE);
			else
				nx.sz[i] = SW'(sz_q[i]);
			if (2'(i) >= d)
				nx.sz[i] = SW'(1);
		end
		case (nx.act)
			fgim_pkg::ACT_JOIN: begin
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < d) begin
						nx.neg[i] = cin[i][31];
						nx.dvd[i] = cin[i][31] ? 32'(-cin[i]) : cin[i];
					end
				end
			end
			fgim_pkg::ACT_SPLIT, fgim_pkg::ACT_NEG: begin
				nx.dvd[2] = 32'(index_in);
			end
			default: ;
		endcase
	end

	assign in_ready  = !vld_s1 || req_ready;
	assign req_valid = vld_s1;
	assign req       = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_ready)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			req_s1 <= nx;
	end

endmodule

// ===== rtl/core/fgim_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgim_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module fgim_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);

	logic [W-1:0] mem [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic         push;
	logic         pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wp_q] <= wr_data;
	end

endmodule

// ===== rtl/core/fgim_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgim_back
// Pipelined restoring dividers (three lanes, then one), wrap and negate,
// then the two-multiply linear index and the output register.
// ----------------------------------------------------------------------------
module fgim_back #(
	parameter int MAX_SIDE = 1024,
	parameter int SW       = $clog2(MAX_SIDE + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  logic [3*SW+101:0]                    req,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [fgim_pkg::COORD_W-1:0]  coord_out_0,
	output logic signed [fgim_pkg::COORD_W-1:0]  coord_out_1,
	output logic signed [fgim_pkg::COORD_W-1:0]  coord_out_2,
	output logic [fgim_pkg::INDEX_W-1:0]         index_out,
	output logic                                 range_error
);

	localparam int NST = fgim_pkg::DIV_STAGES;
	localparam int DW  = fgim_pkg::DVD_W;
	localparam int CW  = fgim_pkg::COORD_W;

	typedef struct packed {
		fgim_pkg::act_t          act;
		logic                    zc;
		logic [2:0][SW-1:0]      sz;
		logic [2:0][DW-1:0]      dvd;
		logic [2:0]              neg;
	} req_t;

	typedef struct packed {
		req_t                r_req;
		logic [2:0][SW-1:0]  r;
		logic [2:0][DW-1:0]  q;
	} sa_t;

	typedef struct packed {
		fgim_pkg::act_t      act;
		logic                zc;
		logic [2:0][SW-1:0]  sz;
		logic [2:0][SW-1:0]  w;
		logic [SW-1:0]       loc2;
		logic [SW-1:0]       r;
		logic [DW-1:0]       q;
	} sb_t;

	function automatic logic [SW+DW-1:0] dstep(input logic [SW-1:0] r,
		input logic [DW-1:0] q, input logic [SW-1:0] dv);
		logic [SW:0]   t;
		logic [DW-1:0] qq;
		t  = {r, q[DW-1]};
		qq = {q[DW-2:0], 1'b0};
		if (t >= {1'b0, dv}) begin
			t     = t - {1'b0, dv};
			qq[0] = 1'b1;
		end
		return {t[SW-1:0], qq};
	endfunction

	logic en;
	sa_t  a_src [NST];
	logic a_vsrc [NST];
	sa_t  a_s [NST];
	logic a_v [NST];
	sb_t  b_src [NST];
	logic b_vsrc [NST];
	sb_t  b_s [NST];
	logic b_v [NST];

	assign en        = !out_valid || out_ready;
	assign req_ready = en;

	always_comb begin
		a_src[0]       = '0;
		a_src[0].r_req = req_t'(req);
		a_src[0].q     = a_src[0].r_req.dvd;
		a_vsrc[0]      = req_valid;
	end

	for (genvar k = 0; k < NST; k++) begin : g_a
		sa_t nx;
		if (k > 0) begin : g_link
			assign a_src[k]  = a_s[k-1];
			assign a_vsrc[k] = a_v[k-1];
		end
		always_comb begin
			nx = a_src[k];
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < fgim_pkg::DIV_STEPS; j++)
					{nx.r[i], nx.q[i]} = dstep(nx.r[i], nx.q[i], nx.r_req.sz[i]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				a_v[k] <= 1'b0;
			else if (en)
				a_v[k] <= a_vsrc[k];
		end
		always_ff @(posedge clk) begin
			if (en)
				a_s[k] <= nx;
		end
	end

	always_comb begin
		b_src[0]      = '0;
		b_src[0].act  = a_s[NST-1].r_req.act;
		b_src[0].zc   = a_s[NST-1].r_req.zc;
		b_src[0].sz   = a_s[NST-1].r_req.sz;
		for (int i = 0; i < 3; i++) begin
			if (a_s[NST-1].r_req.neg[i] && a_s[NST-1].r[i] != '0)
				b_src[0].w[i] = a_s[NST-1].r_req.sz[i] - a_s[NST-1].r[i];
			else
				b_src[0].w[i] = a_s[NST-1].r[i];
		end
		b_src[0].loc2 = a_s[NST-1].r[2];
		b_src[0].q    = a_s[NST-1].q[2];
		b_vsrc[0]     = a_v[NST-1];
	end

	for (genvar k = 0; k < NST; k++) begin : g_b
		sb_t nx;
		if (k > 0) begin : g_link
			assign b_src[k]  = b_s[k-1];
			assign b_vsrc[k] = b_v[k-1];
		end
		always_comb begin
			nx = b_src[k];
			for (int j = 0; j < fgim_pkg::DIV_STEPS; j++)
				{nx.r, nx.q} = dstep(nx.r, nx.q, nx.sz[1]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				b_v[k] <= 1'b0;
			else if (en)
				b_v[k] <= b_vsrc[k];
		end
		always_ff @(posedge clk) begin
			if (en)
				b_s[k] <= nx;
		end
	end

	// final lookup, zero-centring and first product
	sb_t                  f;
	logic [2:0][SW-1:0]   loc;
	logic [2:0][SW-1:0]   l;
	logic [2:0][CW-1:0]   c;
	logic                 rerr;
	logic signed [SW:0]   cv;

	logic                 vld_m1;
	fgim_pkg::act_t       act_m1;
	logic                 rerr_m1;
	logic [2:0][CW-1:0]   c_m1;
	logic [2*SW-1:0]      prod_m1;
	logic [SW-1:0]        l1_m1;
	logic [SW-1:0]        l2_m1;
	logic [SW-1:0]        sz2_m1;

	always_comb begin
		f      = b_s[NST-1];
		loc[0] = f.q[SW-1:0];
		loc[1] = f.r;
		loc[2] = f.loc2;
		rerr   = (f.act == fgim_pkg::ACT_SPLIT || f.act == fgim_pkg::ACT_NEG)
			&& (f.q >= DW'(f.sz[0]));
		c = '0;
		l = '0;
		for (int i = 0; i < 3; i++) begin
			cv = $signed({1'b0, loc[i]});
			if (f.zc && loc[i] > (f.sz[i] >> 1))
				cv = cv - $signed({1'b0, f.sz[i]});
			if (f.act == fgim_pkg::ACT_SPLIT && !rerr)
				c[i] = CW'(cv);
			case (f.act)
				fgim_pkg::ACT_JOIN: l[i] = f.w[i];
				fgim_pkg::ACT_NEG:  l[i] = (loc[i] == '0) ? '0 : f.sz[i] - loc[i];
				default:            l[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_m1 <= 1'b0;
		else if (en)
			vld_m1 <= b_v[NST-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_m1  <= f.act;
			rerr_m1 <= rerr;
			c_m1    <= c;
			prod_m1 <= l[0] * f.sz[1];
			l1_m1   <= l[1];
			l2_m1   <= l[2];
			sz2_m1  <= f.sz[2];
		end
	end

	logic [3*SW:0] lin;

	always_comb begin
		lin = ({1'b0, prod_m1} + (2*SW+1)'(l1_m1)) * sz2_m1 + (3*SW+1)'(l2_m1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= vld_m1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coord_out_0 <= c_m1[0];
			coord_out_1 <= c_m1[1];
			coord_out_2 <= c_m1[2];
			range_error <= rerr_m1;
			if ((act_m1 == fgim_pkg::ACT_JOIN || act_m1 == fgim_pkg::ACT_NEG) && !rerr_m1)
				index_out <= fgim_pkg::INDEX_W'(lin);
			else
				index_out <= '0;
		end
	end

`ifndef NO_ASSERTIONS
	a_rerr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> index_out == '0 && coord_out_0 == '0
		&& coord_out_1 == '0 && coord_out_2 == '0)
		else $error("range error result carries data");
	a_coord_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (coord_out_0 != '0 || coord_out_1 != '0 || coord_out_2 != '0)
		|-> index_out == '0 && !range_error)
		else $error("coordinates and index both set");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("stalled result dropped");
`endif

endmodule

// ===== rtl/core/fft_grid_index_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fft_grid_index_map
// Row-major FFT grid address mapper: index to coordinates, coordinates to
// index with periodic wrap, and index of the negated wavevector.
// ----------------------------------------------------------------------------
//  channel | signals                                         | direction
//  input   | in_valid/in_ready, action, index_in, zc, coords | request in
//  result  | out_valid/out_ready, coord_out_*, index_out, err | result out
//  config  | wr_en, wr_index, wr_data                        | write only
//
//  One request per cycle sustained while out_ready stays high; each result is
//  carried through 20 registers (front register, queue, 16 divider stages
//  at 4 quotient bits each, two multiply stages).
//  Reset clears all valids; configuration returns to 3 dims of 64 points.
//  A stalled result stops the back pipeline; the queue lets the front keep
//  taking requests until it fills.
module fft_grid_index_map #(
	parameter int MAX_SIDE = 1024,
	parameter int MAX_DIMS = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [1:0]                           wr_index,
	input  logic [fgim_pkg::CFG_W-1:0]           wr_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           action,
	input  logic [fgim_pkg::INDEX_W-1:0]         index_in,
	input  logic                                 zero_centered,
	input  logic signed [31:0]                   coord_in_0,
	input  logic signed [31:0]                   coord_in_1,
	input  logic signed [31:0]                   coord_in_2,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [fgim_pkg::COORD_W-1:0]  coord_out_0,
	output logic signed [fgim_pkg::COORD_W-1:0]  coord_out_1,
	output logic signed [fgim_pkg::COORD_W-1:0]  coord_out_2,
	output logic [fgim_pkg::INDEX_W-1:0]         index_out,
	output logic                                 range_error
);

	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int REQ_W = 3 * SW + 102;

	logic             f_valid;
	logic             f_ready;
	logic [REQ_W-1:0] f_req;
	logic             b_valid;
	logic             b_ready;
	logic [REQ_W-1:0] b_req;

	fgim_front #(.MAX_SIDE(MAX_SIDE), .MAX_DIMS(MAX_DIMS), .SW(SW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .index_in(index_in), .zero_centered(zero_centered),
		.coord_in_0(coord_in_0), .coord_in_1(coord_in_1), .coord_in_2(coord_in_2),
		.req_valid(f_valid), .req_ready(f_ready), .req(f_req)
	);

	fgim_queue #(.W(REQ_W)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_req)
	);

	fgim_back #(.MAX_SIDE(MAX_SIDE), .SW(SW)) u_back (
		.clk(clk), .arst_n(arst_n),
		.req_valid(b_valid), .req_ready(b_ready), .req(b_req),
		.out_valid(out_valid), .out_ready(out_ready),
		.coord_out_0(coord_out_0), .coord_out_1(coord_out_1),
		.coord_out_2(coord_out_2), .index_out(index_out),
		.range_error(range_error)
	);

endmodule
